### sv/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// bcmc_pkg
// Shared types and constants of the bead chain move checker: request kinds,
// register map, fixed field widths and the bundles passed between units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcmc_pkg;

    // Defaults for the top level parameters
    localparam int MAX_BEADS_DEF  = 64;
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 6;
    localparam int IN_W    = 24;
    localparam int CHAIN_W = 7;
    localparam int LIMIT_W = 16;

    // Distance arithmetic widths
    localparam int DIFF_CAP = 65536;          // clamp on each coordinate difference
    localparam int MAG_W    = 17;             // clamped magnitude
    localparam int SQD_W    = 33;             // square of a clamped magnitude
    localparam int SUM_W    = 34;             // sum of three squares
    localparam int LSQ_W    = 2 * LIMIT_W;    // square of a limit

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register reset values
    localparam int CHAIN_RESET    = 2;
    localparam int OVERLAP_RESET  = 0;
    localparam int BOND_MIN_RESET = 0;
    localparam int BOND_MAX_RESET = 65535;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_CHECK  = 2'd1,
        KIND_COMMIT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_CHAIN_LENGTH = 2'd0,
        REG_OVERLAP      = 2'd1,
        REG_BOND_MIN     = 2'd2,
        REG_BOND_MAX     = 2'd3
    } reg_idx_t;

    // Limits handed from the register block to the datapath
    typedef struct packed {
        logic [CHAIN_W-1:0] chain_length;
        logic [LSQ_W-1:0]   overlap_sq;
        logic [LSQ_W-1:0]   bond_lo_sq;
        logic [LSQ_W-1:0]   bond_hi_sq;
    } limits_t;

    // Tag travelling with each bead read of a sweep
    typedef struct packed {
        logic valid;
        logic self_hit;
        logic nbr;
    } tag_t;

endpackage

`default_nettype wire

### sv/bcmc_ram.sv
// ----------------------------------------------------------------------------
// bcmc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/bcmc_regs.sv
// ----------------------------------------------------------------------------
// bcmc_regs
// Configuration registers behind the APB-style port, with the squared
// overlap and bond limits precomputed and the bond interval put in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcmc_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bcmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bcmc_pkg::DATA_W-1:0] pwdata,
    output logic      [bcmc_pkg::DATA_W-1:0] prdata,
    output bcmc_pkg::limits_t                limits
);

    logic [bcmc_pkg::CHAIN_W-1:0] chain_length_reg;
    logic [bcmc_pkg::LIMIT_W-1:0] overlap_reg;
    logic [bcmc_pkg::LIMIT_W-1:0] bond_min_reg;
    logic [bcmc_pkg::LIMIT_W-1:0] bond_max_reg;

    logic [bcmc_pkg::LSQ_W-1:0]   overlap_sq_reg;
    logic [bcmc_pkg::LSQ_W-1:0]   min_sq_reg;
    logic [bcmc_pkg::LSQ_W-1:0]   max_sq_reg;
    logic [bcmc_pkg::LSQ_W-1:0]   lo_sq_reg;
    logic [bcmc_pkg::LSQ_W-1:0]   hi_sq_reg;

    logic                         wr_en;
    bcmc_pkg::reg_idx_t           reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bcmc_pkg::reg_idx_t'(paddr[3:2]);

    // Register writes on the access phase of a write transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg <= bcmc_pkg::CHAIN_W'(bcmc_pkg::CHAIN_RESET);
            overlap_reg      <= bcmc_pkg::LIMIT_W'(bcmc_pkg::OVERLAP_RESET);
            bond_min_reg     <= bcmc_pkg::LIMIT_W'(bcmc_pkg::BOND_MIN_RESET);
            bond_max_reg     <= bcmc_pkg::LIMIT_W'(bcmc_pkg::BOND_MAX_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bcmc_pkg::REG_CHAIN_LENGTH: chain_length_reg <= pwdata[bcmc_pkg::CHAIN_W-1:0];
                bcmc_pkg::REG_OVERLAP:      overlap_reg      <= pwdata[bcmc_pkg::LIMIT_W-1:0];
                bcmc_pkg::REG_BOND_MIN:     bond_min_reg     <= pwdata[bcmc_pkg::LIMIT_W-1:0];
                bcmc_pkg::REG_BOND_MAX:     bond_max_reg     <= pwdata[bcmc_pkg::LIMIT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Square the limits, then order the bond interval in the next cycle
    always_ff @(posedge clk)
    begin
        overlap_sq_reg <= bcmc_pkg::LSQ_W'(overlap_reg) * bcmc_pkg::LSQ_W'(overlap_reg);
        min_sq_reg     <= bcmc_pkg::LSQ_W'(bond_min_reg) * bcmc_pkg::LSQ_W'(bond_min_reg);
        max_sq_reg     <= bcmc_pkg::LSQ_W'(bond_max_reg) * bcmc_pkg::LSQ_W'(bond_max_reg);
        if (min_sq_reg > max_sq_reg)
        begin
            lo_sq_reg <= max_sq_reg;
            hi_sq_reg <= min_sq_reg;
        end
        else
        begin
            lo_sq_reg <= min_sq_reg;
            hi_sq_reg <= max_sq_reg;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            bcmc_pkg::REG_CHAIN_LENGTH: prdata = bcmc_pkg::DATA_W'(chain_length_reg);
            bcmc_pkg::REG_OVERLAP:      prdata = bcmc_pkg::DATA_W'(overlap_reg);
            bcmc_pkg::REG_BOND_MIN:     prdata = bcmc_pkg::DATA_W'(bond_min_reg);
            bcmc_pkg::REG_BOND_MAX:     prdata = bcmc_pkg::DATA_W'(bond_max_reg);
            default:                    prdata = '0;
        endcase
    end

    assign limits.chain_length = chain_length_reg;
    assign limits.overlap_sq   = overlap_sq_reg;
    assign limits.bond_lo_sq   = lo_sq_reg;
    assign limits.bond_hi_sq   = hi_sq_reg;

endmodule

`default_nettype wire

### sv/bcmc_dist.sv
// ----------------------------------------------------------------------------
// bcmc_dist
// Distance pipeline of a sweep: clamped coordinate differences, squares,
// then the sum compared against the overlap and bond limits. Overlap and
// bad bond flags stick until cleared at the start of the next sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcmc_dist #(
    parameter int COORD_BITS = bcmc_pkg::COORD_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  clear,
    input  wire bcmc_pkg::tag_t        issue_tag,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic [COORD_BITS-1:0] pos_z,
    input  wire logic [COORD_BITS-1:0] mem_x,
    input  wire logic [COORD_BITS-1:0] mem_y,
    input  wire logic [COORD_BITS-1:0] mem_z,
    input  wire bcmc_pkg::limits_t     limits,
    output logic                       busy,
    output logic                       overlap_flag,
    output logic                       bad_bond_flag
);

    localparam int WIDE = (COORD_BITS + 1 > bcmc_pkg::MAG_W) ? COORD_BITS + 1
                                                              : bcmc_pkg::MAG_W;
    localparam int PW   = 2 * bcmc_pkg::MAG_W;

    bcmc_pkg::tag_t                   s0_tag_reg;
    bcmc_pkg::tag_t                   s1_tag_reg;
    bcmc_pkg::tag_t                   s2_tag_reg;
    logic [bcmc_pkg::MAG_W-1:0]       mag_x_reg;
    logic [bcmc_pkg::MAG_W-1:0]       mag_y_reg;
    logic [bcmc_pkg::MAG_W-1:0]       mag_z_reg;
    logic [bcmc_pkg::SQD_W-1:0]       sq_x_reg;
    logic [bcmc_pkg::SQD_W-1:0]       sq_y_reg;
    logic [bcmc_pkg::SQD_W-1:0]       sq_z_reg;
    logic [PW-1:0]                    prod_x;
    logic [PW-1:0]                    prod_y;
    logic [PW-1:0]                    prod_z;
    logic [bcmc_pkg::SUM_W-1:0]       dist_sq;
    logic                             hit_overlap;
    logic                             hit_bond;
    logic                             overlap_reg;
    logic                             bad_bond_reg;

    // Magnitude of a signed difference, clamped to the distance cap
    function automatic logic [bcmc_pkg::MAG_W-1:0] clamp_mag(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] diff;
        logic [COORD_BITS:0] mag;
        logic [WIDE-1:0]     mag_wide;
        diff     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        mag      = diff[COORD_BITS] ? (~diff + (COORD_BITS+1)'(1)) : diff;
        mag_wide = WIDE'(mag);
        if (mag_wide > WIDE'(bcmc_pkg::DIFF_CAP))
        begin
            return bcmc_pkg::MAG_W'(bcmc_pkg::DIFF_CAP);
        end
        return mag_wide[bcmc_pkg::MAG_W-1:0];
    endfunction

    assign prod_x = PW'(mag_x_reg) * PW'(mag_x_reg);
    assign prod_y = PW'(mag_y_reg) * PW'(mag_y_reg);
    assign prod_z = PW'(mag_z_reg) * PW'(mag_z_reg);

    assign dist_sq = bcmc_pkg::SUM_W'(sq_x_reg) + bcmc_pkg::SUM_W'(sq_y_reg)
                   + bcmc_pkg::SUM_W'(sq_z_reg);

    assign hit_overlap = !s2_tag_reg.self_hit
                         && (dist_sq <= bcmc_pkg::SUM_W'(limits.overlap_sq));
    assign hit_bond    = s2_tag_reg.nbr
                         && !((dist_sq > bcmc_pkg::SUM_W'(limits.bond_lo_sq))
                              && (dist_sq < bcmc_pkg::SUM_W'(limits.bond_hi_sq)));

    // Advance the tags and accumulate the flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg   <= '0;
            s1_tag_reg   <= '0;
            s2_tag_reg   <= '0;
            overlap_reg  <= 1'b0;
            bad_bond_reg <= 1'b0;
        end
        else
        begin
            s0_tag_reg <= issue_tag;
            s1_tag_reg <= s0_tag_reg;
            s2_tag_reg <= s1_tag_reg;
            if (clear)
            begin
                overlap_reg  <= 1'b0;
                bad_bond_reg <= 1'b0;
            end
            else if (s2_tag_reg.valid)
            begin
                overlap_reg  <= overlap_reg || hit_overlap;
                bad_bond_reg <= bad_bond_reg || hit_bond;
            end
        end
    end

    // Difference and square stages
    always_ff @(posedge clk)
    begin
        mag_x_reg <= clamp_mag(pos_x, mem_x);
        mag_y_reg <= clamp_mag(pos_y, mem_y);
        mag_z_reg <= clamp_mag(pos_z, mem_z);
        sq_x_reg  <= prod_x[bcmc_pkg::SQD_W-1:0];
        sq_y_reg  <= prod_y[bcmc_pkg::SQD_W-1:0];
        sq_z_reg  <= prod_z[bcmc_pkg::SQD_W-1:0];
    end

    assign busy          = s0_tag_reg.valid || s1_tag_reg.valid || s2_tag_reg.valid;
    assign overlap_flag  = overlap_reg;
    assign bad_bond_flag = bad_bond_reg;

endmodule

`default_nettype wire

### sv/bead_chain_move_checker_core.sv
// ----------------------------------------------------------------------------
// bead_chain_move_checker_core
// Keeps bead positions of a chain in one RAM and answers load, check and
// commit requests with one result transfer each.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_valid/in_ready channel (kind, bead_index,
//   coord_x/y/z); each gives exactly one result transfer on out_valid/
//   out_ready (overlap, bad_bond, move_ok). One request is in work at a time.
//   Positions live in a single RAM with a registered read port; a request
//   reads, modifies and writes it back before the next one is taken, so no
//   forwarding is needed.
//   Load, unused kind and a check of a bead outside the chain go straight
//   to S_DONE; a commit of a bead in range first writes it in S_MOVE. A check
//   reads the moved bead, then sweeps every bead of the chain one per cycle
//   through a 3-stage distance pipeline and waits in S_DRAIN until it is
//   empty. The sweep over the RAM read port sets the rate.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, and a stalled receiver holds only the
//   completion of that next request.
//   Reset clears control state and the registers to their defaults; the
//   position RAM is not cleared, and beads must be loaded before use.
//   Configuration may be written only while no request is in work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bead_chain_move_checker_core #(
    parameter int MAX_BEADS  = bcmc_pkg::MAX_BEADS_DEF,
    parameter int COORD_BITS = bcmc_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [bcmc_pkg::KIND_W-1:0]  kind,
    input  wire logic        [bcmc_pkg::INDEX_W-1:0] bead_index,
    input  wire logic signed [bcmc_pkg::IN_W-1:0]    coord_x,
    input  wire logic signed [bcmc_pkg::IN_W-1:0]    coord_y,
    input  wire logic signed [bcmc_pkg::IN_W-1:0]    coord_z,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     overlap,
    output logic                                     bad_bond,
    output logic                                     move_ok,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [bcmc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic        [bcmc_pkg::DATA_W-1:0]  pwdata,
    output logic             [bcmc_pkg::DATA_W-1:0]  prdata,
    output logic                                     pready
);

    localparam int AW = $clog2(MAX_BEADS);
    localparam int RW = 3 * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    overlap_reg, overlap_next;
    logic                    bad_bond_reg, bad_bond_next;
    logic                    move_ok_reg, move_ok_next;
    logic                    sweep_used_reg, sweep_used_next;
    logic                    outside_reg, outside_next;
    logic [AW-1:0]           sweep_idx_reg, sweep_idx_next;
    bcmc_pkg::kind_t         kind_reg, kind_next;

    logic [bcmc_pkg::INDEX_W-1:0] id_reg;
    logic [COORD_BITS-1:0]   dx_reg, dy_reg, dz_reg;
    logic [COORD_BITS-1:0]   px_reg, py_reg, pz_reg;

    bcmc_pkg::limits_t       limits;
    bcmc_pkg::tag_t          issue_tag;
    logic                    in_xfer;
    logic                    id_fits;
    logic                    in_chain;
    logic                    sweep_last;
    int                      n_beads;
    logic [COORD_BITS-1:0]   load_x, load_y, load_z;
    logic [COORD_BITS-1:0]   rd_x, rd_y, rd_z;
    logic [COORD_BITS-1:0]   mv_x, mv_y, mv_z;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [RW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [RW-1:0]           ram_rdata;
    logic                    flag_clear;
    logic                    dist_busy;
    logic                    dist_overlap;
    logic                    dist_bad_bond;

    // Configuration registers
    bcmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .limits  (limits)
    );

    assign pready = 1'b1;

    // Position store: {z, y, x} per bead
    bcmc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BEADS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Distance pipeline of the sweep
    bcmc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (flag_clear),
        .issue_tag     (issue_tag),
        .pos_x         (px_reg),
        .pos_y         (py_reg),
        .pos_z         (pz_reg),
        .mem_x         (rd_x),
        .mem_y         (rd_y),
        .mem_z         (rd_z),
        .limits        (limits),
        .busy          (dist_busy),
        .overlap_flag  (dist_overlap),
        .bad_bond_flag (dist_bad_bond)
    );

    // Sign-extend or truncate the request coordinates
    assign load_x = COORD_BITS'(coord_x);
    assign load_y = COORD_BITS'(coord_y);
    assign load_z = COORD_BITS'(coord_z);

    assign rd_x = ram_rdata[COORD_BITS-1:0];
    assign rd_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_z = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

    // Moved position, wrapping on overflow
    assign mv_x = rd_x + dx_reg;
    assign mv_y = rd_y + dy_reg;
    assign mv_z = rd_z + dz_reg;

    // Beads in use, held to the legal range
    always_comb
    begin
        n_beads = int'(limits.chain_length);
        if (n_beads < 2)
        begin
            n_beads = 2;
        end
        if (n_beads > MAX_BEADS)
        begin
            n_beads = MAX_BEADS;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign id_fits    = int'(bead_index) < MAX_BEADS;
    assign in_chain   = int'(bead_index) < n_beads;
    assign sweep_last = int'(sweep_idx_reg) == n_beads - 1;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        overlap_next    = overlap_reg;
        bad_bond_next   = bad_bond_reg;
        move_ok_next    = move_ok_reg;
        sweep_used_next = sweep_used_reg;
        outside_next    = outside_reg;
        sweep_idx_next  = sweep_idx_reg;
        kind_next       = kind_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(bead_index);
        ram_wdata       = {load_z, load_y, load_x};
        ram_raddr       = AW'(bead_index);
        issue_tag       = '0;
        flag_clear      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next       = bcmc_pkg::kind_t'(kind);
                    sweep_used_next = 1'b0;
                    outside_next    = 1'b0;
                    state_next      = S_DONE;
                    case (bcmc_pkg::kind_t'(kind))
                        bcmc_pkg::KIND_LOAD:
                        begin
                            ram_we = id_fits;
                        end
                        bcmc_pkg::KIND_CHECK:
                        begin
                            if (in_chain)
                            begin
                                sweep_used_next = 1'b1;
                                state_next      = S_MOVE;
                            end
                            else
                            begin
                                outside_next = 1'b1;
                            end
                        end
                        bcmc_pkg::KIND_COMMIT:
                        begin
                            if (id_fits)
                            begin
                                state_next = S_MOVE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                // read data holds the addressed bead
                if (kind_reg == bcmc_pkg::KIND_COMMIT)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(id_reg);
                    ram_wdata  = {mv_z, mv_y, mv_x};
                    state_next = S_DONE;
                end
                else
                begin
                    flag_clear     = 1'b1;
                    sweep_idx_next = '0;
                    state_next     = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                ram_raddr          = sweep_idx_reg;
                issue_tag.valid    = 1'b1;
                issue_tag.self_hit = int'(sweep_idx_reg) == int'(id_reg);
                issue_tag.nbr      = (int'(sweep_idx_reg) + 1 == int'(id_reg))
                                     || (int'(sweep_idx_reg) == int'(id_reg) + 1);
                if (sweep_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    overlap_next   = sweep_used_reg && dist_overlap;
                    bad_bond_next  = sweep_used_reg ? dist_bad_bond : outside_reg;
                    move_ok_next   = sweep_used_reg && !dist_overlap && !dist_bad_bond;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            overlap_reg    <= 1'b0;
            bad_bond_reg   <= 1'b0;
            move_ok_reg    <= 1'b0;
            sweep_used_reg <= 1'b0;
            outside_reg    <= 1'b0;
            sweep_idx_reg  <= '0;
            kind_reg       <= bcmc_pkg::KIND_LOAD;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            overlap_reg    <= overlap_next;
            bad_bond_reg   <= bad_bond_next;
            move_ok_reg    <= move_ok_next;
            sweep_used_reg <= sweep_used_next;
            outside_reg    <= outside_next;
            sweep_idx_reg  <= sweep_idx_next;
            kind_reg       <= kind_next;
        end
    end

    // Capture the request and the moved position
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg <= bead_index;
            dx_reg <= load_x;
            dy_reg <= load_y;
            dz_reg <= load_z;
        end
        if (state_reg == S_MOVE)
        begin
            px_reg <= mv_x;
            py_reg <= mv_y;
            pz_reg <= mv_z;
        end
    end

    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;
    assign bad_bond  = bad_bond_reg;
    assign move_ok   = move_ok_reg;

endmodule

`default_nettype wire
